/* hdl/apjb_pkg.sv */
// Shared types and constants of the audio playout jitter buffer.
package apjb_pkg;

  localparam int unsigned BUF_BYTES = 32768;
  localparam int unsigned AW        = 15;
  localparam int unsigned CNT_W     = 16;

  localparam logic [1:0] MODE_HDR  = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_PER  = 2'd3;

  localparam logic [2:0] V_OK     = 3'd0;
  localparam logic [2:0] V_LATE   = 3'd1;
  localparam logic [2:0] V_AHEAD  = 3'd2;
  localparam logic [2:0] V_BEHIND = 3'd3;
  localparam logic [2:0] V_NONE   = 3'd4;

  localparam logic [2:0] REG_LATENCY = 3'd0;
  localparam logic [2:0] REG_TARGET  = 3'd1;
  localparam logic [2:0] REG_DRIFT   = 3'd2;
  localparam logic [2:0] REG_BLEND   = 3'd3;
  localparam logic [2:0] REG_BEEP    = 3'd4;
  localparam logic [2:0] REG_PERIOD  = 3'd5;

  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_CLR    = 4'd1;
  localparam logic [3:0] OP_LATCH  = 4'd2;
  localparam logic [3:0] OP_DATA   = 4'd3;
  localparam logic [3:0] OP_RD     = 4'd4;
  localparam logic [3:0] OP_HCHK   = 4'd5;
  localparam logic [3:0] OP_HDEC   = 4'd6;
  localparam logic [3:0] OP_HAVG   = 4'd7;
  localparam logic [3:0] OP_REF    = 4'd8;
  localparam logic [3:0] OP_FILL   = 4'd9;
  localparam logic [3:0] OP_DRIFT  = 4'd10;
  localparam logic [3:0] OP_DRIFT2 = 4'd11;
  localparam logic [3:0] OP_PCALC  = 4'd12;
  localparam logic [3:0] OP_PEND   = 4'd13;
  localparam logic [3:0] OP_OUT    = 4'd14;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] packet_position;
    logic [63:0] send_time;
    logic [63:0] arrival_time;
    logic [13:0] data_length;
    logic [7:0]  data_byte;
    logic [14:0] read_offset;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         sample_byte;
    logic [2:0]         verdict;
    logic signed [15:0] correction;
    logic [13:0]        advanced_bytes;
  } out_word_t;

  typedef struct packed {
    logic [33:0] latency_ns;
    logic [14:0] target_position;
    logic [14:0] max_drift;
    logic [15:0] blend_q16;
    logic        beep_enable;
    logic [13:0] period_bytes;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] verdict;
    logic       drift;
    logic       fill_done;
    logic       clr_done;
  } dp_stat_t;

endpackage

/* hdl/apjb_ctrl.sv */
// Sequencing state machine of the audio playout jitter buffer.
module apjb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output apjb_pkg::ctrl_cmd_t  cmd,
  input  apjb_pkg::dp_stat_t   stat
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_DATA   = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_HCHK   = 4'd5;
  localparam logic [3:0] S_HDEC   = 4'd6;
  localparam logic [3:0] S_HAVG   = 4'd7;
  localparam logic [3:0] S_REF    = 4'd8;
  localparam logic [3:0] S_FILL   = 4'd9;
  localparam logic [3:0] S_PEND   = 4'd10;
  localparam logic [3:0] S_PCALC  = 4'd11;
  localparam logic [3:0] S_DRIFT  = 4'd12;
  localparam logic [3:0] S_DRIFT2 = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = apjb_pkg::OP_NOP;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = apjb_pkg::OP_CLR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = apjb_pkg::OP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.mode)
          apjb_pkg::MODE_HDR:  state_nxt = S_HCHK;
          apjb_pkg::MODE_DATA: state_nxt = S_DATA;
          apjb_pkg::MODE_READ: state_nxt = S_RD;
          default:             state_nxt = S_PCALC;
        endcase
      end
      S_DATA: begin
        cmd.op    = apjb_pkg::OP_DATA;
        state_nxt = S_OUT;
      end
      S_RD: begin
        cmd.op    = apjb_pkg::OP_RD;
        state_nxt = S_OUT;
      end
      S_HCHK: begin
        cmd.op    = apjb_pkg::OP_HCHK;
        state_nxt = S_HDEC;
      end
      S_HDEC: begin
        cmd.op = apjb_pkg::OP_HDEC;
        if (stat.verdict == apjb_pkg::V_LATE) state_nxt = S_DRIFT;
        else if (stat.verdict == apjb_pkg::V_OK) state_nxt = S_HAVG;
        else state_nxt = S_REF;
      end
      S_HAVG: begin
        cmd.op    = apjb_pkg::OP_HAVG;
        state_nxt = S_DRIFT;
      end
      S_REF: begin
        cmd.op    = apjb_pkg::OP_REF;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.op = apjb_pkg::OP_FILL;
        if (stat.fill_done) begin
          state_nxt = (stat.mode == apjb_pkg::MODE_HDR) ? S_DRIFT : S_PEND;
        end
      end
      S_PEND: begin
        cmd.op    = apjb_pkg::OP_PEND;
        state_nxt = S_OUT;
      end
      S_PCALC: begin
        cmd.op    = apjb_pkg::OP_PCALC;
        state_nxt = S_REF;
      end
      S_DRIFT: begin
        cmd.op    = apjb_pkg::OP_DRIFT;
        state_nxt = stat.drift ? S_DRIFT2 : S_OUT;
      end
      S_DRIFT2: begin
        cmd.op    = apjb_pkg::OP_DRIFT2;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = apjb_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/apjb_dp.sv */
// Datapath of the audio playout jitter buffer: byte store, offsets, averaging, fills.
module apjb_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  apjb_pkg::ctrl_cmd_t  cmd,
  output apjb_pkg::dp_stat_t   stat,
  input  apjb_pkg::cfg_t       cfg,
  input  apjb_pkg::in_word_t   in_data,
  output apjb_pkg::out_word_t  out_data
);

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    if (v < -35'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [7:0] mem [apjb_pkg::BUF_BYTES];

  apjb_pkg::in_word_t  in_r;
  apjb_pkg::out_word_t out_r;

  logic [apjb_pkg::AW-1:0]    base_r, wp_r;
  logic [63:0]                offset_r, p_r;
  logic signed [31:0]         avg_r;
  logic signed [15:0]         corr_r;
  logic [13:0]                left_r;
  logic                       late_r;
  logic [2:0]                 verdict_r;
  logic [apjb_pkg::CNT_W-1:0] cnt_r, len_r;
  logic [13:0]                r_r;
  logic [7:0]                 ref_r, rdata_r;
  logic signed [49:0]         mult_r;
  logic signed [48:0]         m1_r;
  logic [27:0]                m2_r;

  // header checks
  logic [64:0] due;
  logic        late;
  logic [16:0] end_pos;
  logic [2:0]  verdict;
  logic [14:0] t_al;

  assign due     = {1'b0, in_r.send_time} + {31'd0, cfg.latency_ns};
  assign late    = !due[64] && (due[63:0] < in_r.arrival_time);
  assign end_pos = {1'b0, p_r[15:0]} + {3'd0, in_r.data_length};
  assign t_al    = {cfg.target_position[14:2], 2'b00};

  always_comb begin
    if (late_r) verdict = apjb_pkg::V_LATE;
    else if (p_r[63]) verdict = apjb_pkg::V_AHEAD;
    else if ((p_r[62:16] != '0) || (end_pos > 17'd32768)) verdict = apjb_pkg::V_BEHIND;
    else verdict = apjb_pkg::V_OK;
  end

  // running average
  logic signed [32:0] diff;
  logic signed [34:0] avg_sum;
  assign diff    = $signed({1'b0, p_r[15:0], 16'd0}) - 33'(avg_r);
  assign avg_sum = 35'(avg_r) + 35'(mult_r >>> 16);

  // drift detection and correction
  logic signed [33:0] avg34, hi, lo, dev, dev_adj;
  logic [15:0]        t_hi;
  logic signed [16:0] t_lo;
  logic signed [15:0] dq;
  logic signed [17:0] d4;
  logic signed [15:0] dsat;
  logic               drift;
  logic signed [49:0] blend_sum;

  assign avg34   = 34'(avg_r);
  assign t_hi    = {1'b0, cfg.target_position} + {1'b0, cfg.max_drift};
  assign t_lo    = $signed({2'b0, cfg.target_position}) - $signed({2'b0, cfg.max_drift});
  assign hi      = $signed({2'b0, t_hi, 16'd0});
  assign lo      = {t_lo[16], t_lo, 16'd0};
  assign drift   = (avg34 > hi) || (avg34 < lo);
  assign dev     = avg34 - $signed({3'b0, cfg.target_position, 16'd0});
  // truncate toward zero to a multiple of four bytes
  assign dev_adj = dev[33] ? (dev + 34'sd262143) : dev;
  assign dq      = dev_adj[33:18];
  assign d4      = {dq, 2'b00};
  always_comb begin
    if (d4 > 18'sd32767) dsat = 16'sh7fff;
    else if (d4 < -18'sd32768) dsat = 16'sh8000;
    else dsat = d4[15:0];
  end
  assign blend_sum = 50'(m1_r) + $signed({6'd0, m2_r, 16'd0});

  // period length
  logic               apply;
  logic signed [17:0] r_raw;
  logic [13:0]        r_clamp;
  assign apply = (corr_r > 16'sd1) || (corr_r < -16'sd1);
  assign r_raw = $signed({4'd0, cfg.period_bytes}) + (apply ? 18'(corr_r) : 18'sd0);
  always_comb begin
    if (r_raw < 0) r_clamp = '0;
    else if (r_raw > 18'sd8192) r_clamp = 14'd8192;
    else r_clamp = r_raw[13:0];
  end

  // fill pattern
  logic signed [7:0] ref_s, beep_v, fill_v;
  assign ref_s  = ref_r;
  assign beep_v = (ref_s > 8'sd0) ? (ref_s - 8'sd4) : (ref_s + 8'sd4);
  assign fill_v = (cfg.beep_enable && (cnt_r[1:0] == 2'b00)) ? beep_v : ref_s;

  logic fill_done;
  assign fill_done = (cnt_r == len_r);

  // store ports
  logic                    we, re;
  logic [apjb_pkg::AW-1:0] waddr, raddr;
  logic [7:0]              wdata;

  always_comb begin
    we    = 1'b0;
    waddr = base_r + cnt_r[apjb_pkg::AW-1:0];
    wdata = fill_v;
    re    = 1'b0;
    raddr = base_r;
    unique case (cmd.op)
      apjb_pkg::OP_CLR: begin
        we    = 1'b1;
        waddr = cnt_r[apjb_pkg::AW-1:0];
        wdata = '0;
      end
      apjb_pkg::OP_FILL: we = !fill_done;
      apjb_pkg::OP_DATA: begin
        we    = (left_r != '0);
        waddr = wp_r;
        wdata = in_r.data_byte;
      end
      apjb_pkg::OP_RD: begin
        re    = 1'b1;
        raddr = base_r + in_r.read_offset;
      end
      apjb_pkg::OP_HDEC: re = 1'b1;
      apjb_pkg::OP_PCALC: begin
        re    = 1'b1;
        raddr = base_r - 15'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      wp_r     <= '0;
      offset_r <= 64'hC000000000000000;
      avg_r    <= '0;
      corr_r   <= '0;
      left_r   <= '0;
      cnt_r    <= '0;
    end else begin
      unique case (cmd.op)
        apjb_pkg::OP_CLR:   cnt_r <= cnt_r + 16'd1;
        apjb_pkg::OP_LATCH: in_r <= in_data;
        apjb_pkg::OP_DATA: begin
          if (left_r != '0) begin
            wp_r   <= wp_r + 15'd1;
            left_r <= left_r - 14'd1;
          end
        end
        apjb_pkg::OP_HCHK: begin
          late_r <= late;
          p_r    <= in_r.packet_position - offset_r;
        end
        apjb_pkg::OP_HDEC: begin
          verdict_r <= verdict;
          left_r    <= (verdict == apjb_pkg::V_OK) ? in_r.data_length : 14'd0;
          if (verdict == apjb_pkg::V_OK) begin
            wp_r   <= base_r + p_r[14:0];
            mult_r <= diff * $signed({1'b0, cfg.blend_q16});
          end else if (verdict != apjb_pkg::V_LATE) begin
            len_r    <= 16'(apjb_pkg::BUF_BYTES);
            offset_r <= in_r.packet_position - {49'd0, t_al};
            avg_r    <= $signed({1'b0, t_al, 16'd0});
          end
        end
        apjb_pkg::OP_HAVG: avg_r <= sat32(avg_sum);
        apjb_pkg::OP_REF: begin
          ref_r <= rdata_r;
          cnt_r <= '0;
        end
        apjb_pkg::OP_FILL: if (!fill_done) cnt_r <= cnt_r + 16'd1;
        apjb_pkg::OP_DRIFT: begin
          if (drift) begin
            corr_r <= dsat;
            m1_r   <= $signed(17'd58982) * avg_r;
            m2_r   <= 13'd6554 * cfg.target_position;
          end
        end
        apjb_pkg::OP_DRIFT2: avg_r <= sat32(35'(blend_sum >>> 16));
        apjb_pkg::OP_PCALC: begin
          r_r   <= r_clamp;
          len_r <= {2'b0, r_clamp};
          if (apply) corr_r <= '0;
        end
        apjb_pkg::OP_PEND: begin
          base_r   <= base_r + {1'b0, r_r};
          offset_r <= offset_r + {50'd0, r_r};
        end
        apjb_pkg::OP_OUT: begin
          out_r.sample_byte    <= (in_r.mode == apjb_pkg::MODE_READ) ? rdata_r : 8'd0;
          out_r.verdict        <= (in_r.mode == apjb_pkg::MODE_HDR) ? verdict_r
                                                                    : apjb_pkg::V_NONE;
          out_r.correction     <= corr_r;
          out_r.advanced_bytes <= (in_r.mode == apjb_pkg::MODE_PER) ? r_r : 14'd0;
        end
        default: ;
      endcase
    end
  end

  assign out_data       = out_r;
  assign stat.mode      = in_r.mode;
  assign stat.verdict   = verdict;
  assign stat.drift     = drift;
  assign stat.fill_done = fill_done;
  assign stat.clr_done  = (cnt_r[apjb_pkg::AW-1:0] == '1);

endmodule

/* hdl/audio_playout_jitter_buffer.sv */
// Top level of the audio playout jitter buffer: register port, controller and datapath.
// After reset the 32768-byte store is cleared, one byte per cycle, before the first word
// is taken; register writes are taken meanwhile. One word is in work at a time through a
// shared datapath. A header that re-anchors reads one reference byte and then refills
// the whole store through its single write port. A finished result sits in the output
// register while the next word is accepted.
module audio_playout_jitter_buffer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  apjb_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output apjb_pkg::out_word_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  apjb_pkg::cfg_t      cfg_r;
  apjb_pkg::ctrl_cmd_t cmd;
  apjb_pkg::dp_stat_t  stat;
  logic [2:0]          reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.latency_ns      <= 34'd50000000;
      cfg_r.target_position <= 15'd8800;
      cfg_r.max_drift       <= 15'd4;
      cfg_r.blend_q16       <= 16'd13;
      cfg_r.beep_enable     <= 1'b0;
      cfg_r.period_bytes    <= 14'd1764;
    end else if (wr_en) begin
      unique case (reg_idx)
        apjb_pkg::REG_LATENCY: cfg_r.latency_ns      <= pwdata[33:0];
        apjb_pkg::REG_TARGET:  cfg_r.target_position <= pwdata[14:0];
        apjb_pkg::REG_DRIFT:   cfg_r.max_drift       <= pwdata[14:0];
        apjb_pkg::REG_BLEND:   cfg_r.blend_q16       <= pwdata[15:0];
        apjb_pkg::REG_BEEP:    cfg_r.beep_enable     <= pwdata[0];
        apjb_pkg::REG_PERIOD:  cfg_r.period_bytes    <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      apjb_pkg::REG_LATENCY: prdata = {30'd0, cfg_r.latency_ns};
      apjb_pkg::REG_TARGET:  prdata = {49'd0, cfg_r.target_position};
      apjb_pkg::REG_DRIFT:   prdata = {49'd0, cfg_r.max_drift};
      apjb_pkg::REG_BLEND:   prdata = {48'd0, cfg_r.blend_q16};
      apjb_pkg::REG_BEEP:    prdata = {63'd0, cfg_r.beep_enable};
      apjb_pkg::REG_PERIOD:  prdata = {50'd0, cfg_r.period_bytes};
      default:               prdata = '0;
    endcase
  end

  apjb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  apjb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // one word in work at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while previous word still in work");

  // only header results carry a verdict, and then no sample or advance
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.verdict != apjb_pkg::V_NONE) |->
      (out_data.sample_byte == 8'd0) && (out_data.advanced_bytes == 14'd0))
    else $error("header result carries sample or advance");

  // play head never moves more than a quarter of the store
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.advanced_bytes <= 14'd8192))
    else $error("advance beyond clamp");

endmodule

/* tb/sv/audio_playout_jitter_buffer_test.sv */
// Self-checking bench for the audio playout jitter buffer: directed cases, then random streams.
module audio_playout_jitter_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  apjb_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  apjb_pkg::out_word_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [5:0]          paddr;
  logic [63:0]         pwdata;
  logic [63:0]         prdata;
  logic                pready;

  audio_playout_jitter_buffer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predicted block state
  logic [7:0]  audio_mem [apjb_pkg::BUF_BYTES];
  logic [14:0] head_base;
  logic [63:0] stream_offset;
  longint      avg_q16;
  longint      corr_pending;
  logic [14:0] wr_ptr;
  bit          pkt_open;
  int          pkt_left;

  logic [33:0] cfg_latency;
  longint      cfg_target;
  longint      cfg_drift;
  longint      cfg_blend;
  bit          cfg_beep;
  longint      cfg_period;

  apjb_pkg::out_word_t expected_q [$];
  int          errors;
  int          in_gap_pct;
  bit          quiet;
  int          out_hold;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void fill_store(logic [14:0] start, int len, logic [7:0] refb);
    int refv;
    int v;
    logic [14:0] a;
    refv = $signed(refb);
    for (int i = 0; i < len; i++) begin
      v = refv;
      if (cfg_beep && (i % 4) == 0) v = (refv > 0) ? refv - 4 : refv + 4;
      a = start + 15'(i);
      audio_mem[a] = v[7:0];
    end
  endfunction

  function automatic logic [2:0] judge_header(apjb_pkg::in_word_t w);
    logic [64:0] due;
    logic [63:0] p;
    longint      t_al;
    longint      diff;
    longint      d;
    logic [2:0]  v;
    t_al = cfg_target & ~64'sd3;
    pkt_open = 0;
    pkt_left = 0;
    due = {1'b0, w.send_time} + {31'b0, cfg_latency};
    if (due < {1'b0, w.arrival_time}) begin
      v = apjb_pkg::V_LATE;
    end else begin
      p = w.packet_position - stream_offset;
      if (p[63]) v = apjb_pkg::V_AHEAD;
      else if (p + 64'(w.data_length) > 64'(apjb_pkg::BUF_BYTES)) v = apjb_pkg::V_BEHIND;
      else v = apjb_pkg::V_OK;
      if (v != apjb_pkg::V_OK) begin
        fill_store(head_base, apjb_pkg::BUF_BYTES, audio_mem[head_base]);
        stream_offset = w.packet_position - 64'(t_al);
        avg_q16 = t_al * 65536;
      end else begin
        diff = longint'(p) * 65536 - avg_q16;
        wr_ptr = head_base + p[14:0];
        pkt_left = w.data_length;
        pkt_open = w.data_length != 0;
        avg_q16 = sat32(avg_q16 + ((diff * cfg_blend) >>> 16));
      end
    end
    if (avg_q16 > (cfg_target + cfg_drift) * 65536 ||
        avg_q16 < (cfg_target - cfg_drift) * 65536) begin
      d = (avg_q16 - cfg_target * 65536) / 65536;
      d = d / 4 * 4;
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      corr_pending = d;
      avg_q16 = sat32((58982 * avg_q16 + 6554 * cfg_target * 65536) >>> 16);
    end
    return v;
  endfunction

  function automatic longint advance_head();
    longint r;
    r = cfg_period;
    if (corr_pending > 1 || corr_pending < -1) begin
      r += corr_pending;
      corr_pending = 0;
    end
    if (r < 0) r = 0;
    if (r > apjb_pkg::BUF_BYTES / 4) r = apjb_pkg::BUF_BYTES / 4;
    fill_store(head_base, int'(r), audio_mem[head_base + 15'h7fff]);
    head_base = head_base + 15'(r);
    stream_offset += 64'(r);
    return r;
  endfunction

  function automatic apjb_pkg::out_word_t predict_word(apjb_pkg::in_word_t w);
    apjb_pkg::out_word_t o;
    longint r;
    o.sample_byte = 8'd0;
    o.verdict = apjb_pkg::V_NONE;
    o.advanced_bytes = 14'd0;
    case (w.mode)
      apjb_pkg::MODE_HDR: o.verdict = judge_header(w);
      apjb_pkg::MODE_DATA: begin
        if (pkt_open && pkt_left != 0) begin
          audio_mem[wr_ptr] = w.data_byte;
          wr_ptr = wr_ptr + 15'd1;
          pkt_left--;
          if (pkt_left == 0) pkt_open = 0;
        end
      end
      apjb_pkg::MODE_READ: o.sample_byte = audio_mem[head_base + w.read_offset];
      default: begin
        r = advance_head();
        o.advanced_bytes = r[13:0];
      end
    endcase
    o.correction = corr_pending[15:0];
    return o;
  endfunction

  // result checker
  task automatic flag_field(string name, longint e, longint g);
    $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, g);
    errors++;
  endtask

  always @(posedge clk) begin
    apjb_pkg::out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected word expected none actual %h", $time, out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.sample_byte !== e.sample_byte)
          flag_field("sample_byte", e.sample_byte, out_data.sample_byte);
        if (out_data.verdict !== e.verdict)
          flag_field("verdict", e.verdict, out_data.verdict);
        if (out_data.correction !== e.correction)
          flag_field("correction", e.correction, out_data.correction);
        if (out_data.advanced_bytes !== e.advanced_bytes)
          flag_field("advanced_bytes", e.advanced_bytes, out_data.advanced_bytes);
      end
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (out_hold > 0) out_hold--;
    else if (!quiet && $urandom_range(0, 5) == 0) out_hold = $urandom_range(1, 8);
    out_ready <= (out_hold == 0);
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input apjb_pkg::in_word_t w);
    if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_word(w));
  endtask

  function automatic apjb_pkg::in_word_t noise_word(logic [1:0] mode);
    apjb_pkg::in_word_t w;
    w.mode = mode;
    w.packet_position = rnd64();
    w.send_time = rnd64();
    w.arrival_time = rnd64();
    w.data_length = 14'($urandom_range(0, 8192));
    w.data_byte = 8'($urandom);
    w.read_offset = 15'($urandom);
    return w;
  endfunction

  task automatic send_header(logic [63:0] pos, logic [63:0] st, logic [63:0] at,
                             int dlen);
    apjb_pkg::in_word_t w;
    w = noise_word(apjb_pkg::MODE_HDR);
    w.packet_position = pos;
    w.send_time = st;
    w.arrival_time = at;
    w.data_length = 14'(dlen);
    send_word(w);
  endtask

  task automatic send_byte(logic [7:0] b);
    apjb_pkg::in_word_t w;
    w = noise_word(apjb_pkg::MODE_DATA);
    w.data_byte = b;
    send_word(w);
  endtask

  task automatic send_read(int off);
    apjb_pkg::in_word_t w;
    w = noise_word(apjb_pkg::MODE_READ);
    w.read_offset = 15'(off);
    send_word(w);
  endtask

  task automatic send_period();
    send_word(noise_word(apjb_pkg::MODE_PER));
  endtask

  // on-time packet at logical position p with nbytes of its data bytes
  task automatic send_packet(int p, int dlen, int nbytes);
    logic [63:0] st;
    st = rnd64();
    send_header(stream_offset + 64'(p), st, st + rnd64() % (64'(cfg_latency) + 1), dlen);
    for (int i = 0; i < nbytes; i++) send_byte(8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 6'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      apjb_pkg::REG_LATENCY: cfg_latency = val[33:0];
      apjb_pkg::REG_TARGET:  cfg_target = val[14:0];
      apjb_pkg::REG_DRIFT:   cfg_drift = val[14:0];
      apjb_pkg::REG_BLEND:   cfg_blend = val[15:0];
      apjb_pkg::REG_BEEP:    cfg_beep = val[0];
      default:               cfg_period = val[13:0];
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(logic [33:0] lat, int t, int md, int bl, bit bp, int per);
    write_reg(apjb_pkg::REG_LATENCY, 64'(lat));
    write_reg(apjb_pkg::REG_TARGET, 64'(t));
    write_reg(apjb_pkg::REG_DRIFT, 64'(md));
    write_reg(apjb_pkg::REG_BLEND, 64'(bl));
    write_reg(apjb_pkg::REG_BEEP, 64'(bp));
    write_reg(apjb_pkg::REG_PERIOD, 64'(per));
  endtask

  task automatic test_directed();
    logic [63:0] st;
    // first header misses the reset anchor and re-anchors
    send_header(64'd0, 64'd100, 64'd100, 0);
    send_read(0);
    send_read(32767);
    send_packet(0, 4, 0);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(8'h55);                          // stray word, ignored
    send_header(64'd0, 64'd0, 64'hffff_ffff_ffff_ffff, 3);   // late
    st = 64'd1000;
    send_header(stream_offset + 64'd10, st, st + 64'(cfg_latency), 1);     // exactly due
    send_header(stream_offset + 64'd10, st, st + 64'(cfg_latency) + 1, 1); // one ns late
    send_packet(24576, 8192, 2);               // longest packet, cut short by next header
    send_packet(32768, 0, 0);                  // empty packet at the window end
    send_period();
    send_read(5);
    // send time near wrap: due overflows, never late; one byte before window
    send_header(stream_offset - 64'd1, 64'hffff_ffff_ffff_fff0, 64'hffff_ffff_ffff_ffff, 0);
    send_header(stream_offset + 64'd24577, 64'd0, 64'd0, 8192);  // past window end
    drain();
  endtask

  task automatic test_extremes();
    write_all(34'd10000000000, 32767, 32767, 65535, 1'b1, 8192);
    send_packet(100, 2, 2);
    send_period();
    send_read(32767);
    drain();
    write_all(34'd0, 0, 0, 65535, 1'b1, 0);
    send_packet(32000, 3, 3);                  // big positive drift
    send_period();
    send_read(0);
    send_packet(0, 1, 1);
    send_period();
    drain();
    write_all(34'd0, 32767, 0, 0, 1'b0, 0);
    send_packet(5, 1, 1);                      // average far below target
    send_period();
    send_read(1);
    drain();
  endtask

  task automatic random_phase(int items);
    int n;
    int k;
    int dlen;
    logic [63:0] st;
    n = 0;
    while (n < items) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 12);
        send_packet($urandom_range(0, apjb_pkg::BUF_BYTES - dlen), dlen,
                    ($urandom_range(0, 9) == 0) ? dlen / 2 : dlen);
        n += 1 + dlen;
      end else if (k < 72) begin
        send_read($urandom_range(0, 32767));
        n++;
      end else if (k < 84) begin
        send_period();
        n++;
      end else if (k < 93) begin
        st = {1'b0, rnd64()} >> 1;
        send_header(rnd64(), st, st + 64'(cfg_latency) + 1 + 64'($urandom), $urandom_range(0, 8192));
        n++;
      end else if (k < 97) begin
        send_byte(8'($urandom));
      end else begin
        st = rnd64();
        send_header(rnd64(), st, st, $urandom_range(0, 8192));   // almost surely off window
        n++;
      end
    end
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      write_all(34'($urandom_range(0, 1000000)) * 34'd10000, $urandom_range(0, 32767),
                $urandom_range(0, 300), $urandom_range(0, 65535), 1'($urandom),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8192) : $urandom_range(0, 200));
      in_gap_pct = (ph == 1) ? 0 : 20;
      random_phase(170);
    end
    // final stretch runs with no idling
    quiet = 1;
    in_gap_pct = 0;
    write_all(34'd50000000, 8800, 4, 13, 1'b0, 64);
    random_phase(120);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    in_gap_pct = 0;
    quiet = 0;
    out_hold = 0;
    for (int i = 0; i < apjb_pkg::BUF_BYTES; i++) audio_mem[i] = 8'd0;
    head_base = '0;
    stream_offset = 64'hc000_0000_0000_0000;
    avg_q16 = 0;
    corr_pending = 0;
    wr_ptr = '0;
    pkt_open = 0;
    pkt_left = 0;
    cfg_latency = 34'd50000000;
    cfg_target = 8800;
    cfg_drift = 4;
    cfg_blend = 13;
    cfg_beep = 0;
    cfg_period = 1764;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_extremes();
    test_random();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* filelist.f */
hdl/apjb_pkg.sv
hdl/apjb_ctrl.sv
hdl/apjb_dp.sv
hdl/audio_playout_jitter_buffer.sv
tb/sv/audio_playout_jitter_buffer_test.sv
